// ----- design/pcxrle_pkg.sv -----
// Package with shared constants, register indexes and control structs of the PCX row decoder.
package pcxrle_pkg;

  // Default width of the column and row counters and of the dimension registers
  localparam int unsigned DIM_BITS_DEF = 16;

  // Configuration port layout
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 2;

  // Register reset values
  localparam int unsigned LINE_BYTES_RST   = 320;
  localparam int unsigned IMAGE_WIDTH_RST  = 320;
  localparam int unsigned IMAGE_HEIGHT_RST = 200;

  // Byte coding: both top bits set marks a run header, low six bits are the count
  localparam logic [1:0]  RUN_MARK  = 2'b11;
  localparam int unsigned RUN_CNT_W = 6;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LINE_BYTES   = 2'd0,
    CFG_IMAGE_WIDTH  = 2'd1,
    CFG_IMAGE_HEIGHT = 2'd2
  } cfg_idx_e;

  // Controller to datapath
  typedef struct packed {
    logic in_run;   // controller is stepping a stored span
    logic accept;   // input byte transfer this cycle
    logic step;     // advance the stored span by one column
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic slot_free;  // output register can take a pixel this cycle
    logic span_more;  // current span continues after this column
  } status_t;

endpackage

// ----- design/pcxrle_intf.sv -----
// Handshake channel interfaces of the PCX row decoder: byte input, pixel output, register writes.
interface pcxrle_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;

  modport source (output valid, output stream_byte, input ready);
  modport sink (input valid, input stream_byte, output ready);
endinterface

interface pcxrle_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_value;
  logic       row_last;
  logic       image_last;
  logic       item_last;

  modport source (output valid, output pixel_value, output row_last, output image_last,
                  output item_last, input ready);
  modport sink (input valid, input pixel_value, input row_last, input image_last,
                input item_last, output ready);
endinterface

interface pcxrle_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [pcxrle_pkg::CFG_IDX_W-1:0]  reg_index;
  logic [pcxrle_pkg::CFG_DATA_W-1:0] wr_data;

  modport source (output valid, output reg_index, output wr_data, input ready);
  modport sink (input valid, input reg_index, input wr_data, output ready);
endinterface

// ----- design/pcxrle_ctrl.sv -----
// Controller state machine of the PCX row decoder: takes bytes and sequences runs.
module pcxrle_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  pcxrle_pkg::status_t sts_i,
  output pcxrle_pkg::cmd_t    cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } state_e;

  state_e state_q, state_d;

  // Decide commands and next state
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    state_d    = state_q;
    case (state_q)
      S_IDLE: begin
        in_ready_o  = sts_i.slot_free;
        cmd_o.accept = in_valid_i && sts_i.slot_free;
        if (cmd_o.accept && sts_i.span_more) begin
          state_d = S_RUN;
        end
      end
      S_RUN: begin
        cmd_o.in_run = 1'b1;
        cmd_o.step   = sts_i.slot_free;
        if (cmd_o.step && !sts_i.span_more) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- design/pcxrle_dp.sv -----
// Datapath of the PCX row decoder: registers, run state, line counters and pixel output register.
module pcxrle_dp #(
  parameter int unsigned DIM_BITS = pcxrle_pkg::DIM_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  pcxrle_pkg::cmd_t                  cmd_i,
  output pcxrle_pkg::status_t               sts_o,
  input  logic [7:0]                        stream_byte_i,
  input  logic                              cfg_valid_i,
  input  logic [pcxrle_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [pcxrle_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic [7:0]                        pixel_value_o,
  output logic                              row_last_o,
  output logic                              image_last_o,
  output logic                              item_last_o
);

  localparam int unsigned CW = pcxrle_pkg::RUN_CNT_W;

  logic [DIM_BITS-1:0] line_bytes_q, image_width_q, image_height_q;
  logic                run_waiting_q;
  logic [CW-1:0]       run_length_q;
  logic [CW-1:0]       rem_q;
  logic [7:0]          value_q;
  logic [DIM_BITS-1:0] col_q, row_q;
  logic                out_valid_q;
  logic [7:0]          pix_q;
  logic                row_last_q, image_last_q, item_last_q;

  logic [DIM_BITS-1:0] lb_eff, h_eff, vis;
  logic                is_header, span_act, do_step;
  logic [7:0]          cur_value;
  logic [CW-1:0]       cur_rem;
  logic [DIM_BITS:0]   col_inc;
  logic                ge_lb, line_done, emit, rl, last_row, span_more, slot_free;

  // Effective dimensions: zero line length and zero height act as one
  assign lb_eff = (line_bytes_q == '0) ? DIM_BITS'(1) : line_bytes_q;
  assign h_eff  = (image_height_q == '0) ? DIM_BITS'(1) : image_height_q;
  assign vis    = (image_width_q < lb_eff) ? image_width_q : lb_eff;

  // Select the span source: stored run or the byte in transfer
  assign is_header = (stream_byte_i[7:6] == pcxrle_pkg::RUN_MARK);
  assign cur_value = cmd_i.in_run ? value_q : stream_byte_i;
  assign cur_rem   = cmd_i.in_run ? rem_q :
                     (run_waiting_q ? run_length_q : CW'(1));
  assign span_act  = cmd_i.in_run ||
                     (run_waiting_q ? (run_length_q != '0) : !is_header);
  assign do_step   = cmd_i.step || (cmd_i.accept && span_act);

  // Column step: emit when visible, close the line at its end
  assign col_inc   = {1'b0, col_q} + (DIM_BITS+1)'(1);
  assign ge_lb     = (col_q >= lb_eff);
  assign line_done = ge_lb || (col_inc >= {1'b0, lb_eff});
  assign emit      = (col_q < vis);
  assign rl        = (col_q == vis - DIM_BITS'(1));
  assign last_row  = (row_q >= h_eff - DIM_BITS'(1));
  assign span_more = span_act && !line_done && (cur_rem != CW'(1));
  assign slot_free = !out_valid_q || out_ready_i;

  assign sts_o.slot_free = slot_free;
  assign sts_o.span_more = span_more;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_bytes_q   <= DIM_BITS'(pcxrle_pkg::LINE_BYTES_RST);
      image_width_q  <= DIM_BITS'(pcxrle_pkg::IMAGE_WIDTH_RST);
      image_height_q <= DIM_BITS'(pcxrle_pkg::IMAGE_HEIGHT_RST);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        pcxrle_pkg::CFG_LINE_BYTES:   line_bytes_q   <= cfg_data_i[DIM_BITS-1:0];
        pcxrle_pkg::CFG_IMAGE_WIDTH:  image_width_q  <= cfg_data_i[DIM_BITS-1:0];
        pcxrle_pkg::CFG_IMAGE_HEIGHT: image_height_q <= cfg_data_i[DIM_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Run header tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_waiting_q <= 1'b0;
      run_length_q  <= '0;
    end else if (cmd_i.accept) begin
      if (run_waiting_q) begin
        run_waiting_q <= 1'b0;
        run_length_q  <= '0;
      end else if (is_header) begin
        run_waiting_q <= 1'b1;
        run_length_q  <= stream_byte_i[CW-1:0];
      end
    end
  end

  // Line and row counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (do_step) begin
      if (line_done) begin
        col_q <= '0;
        row_q <= last_row ? '0 : row_q + DIM_BITS'(1);
      end else begin
        col_q <= col_inc[DIM_BITS-1:0];
      end
    end
  end

  // Hold the rest of a span
  always_ff @(posedge clk_i) begin
    if (do_step && span_more) begin
      value_q <= cur_value;
      rem_q   <= cur_rem - CW'(1);
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (do_step && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_step && emit) begin
      pix_q        <= cur_value;
      row_last_q   <= rl;
      image_last_q <= rl && last_row;
      item_last_q  <= rl || (cur_rem == CW'(1));
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_value_o = pix_q;
  assign row_last_o    = row_last_q;
  assign image_last_o  = image_last_q;
  assign item_last_o   = item_last_q;

endmodule

// ----- design/pcx_rle_row_decoder.sv -----
// Top level of the PCX row decoder: controller, datapath and channel hookup.
// A literal byte or the first column of a run is handled in the cycle its byte is
// transferred, so literals pass at one byte per cycle. A run data byte covers up to
// 63 columns, one column per cycle, through a single column counter; the input is held
// off for the remaining columns of the run, up to the line end, and a run header byte
// emits nothing. Columns in line padding are stepped but give no pixel. A single output
// register decouples the pixel side; a stalled output stalls column stepping.
module pcx_rle_row_decoder #(
  parameter int unsigned DIM_BITS = pcxrle_pkg::DIM_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  pcxrle_byte_if.sink  stream_i,
  pcxrle_pix_if.source pixel_o,
  pcxrle_cfg_if.sink   cfg_i
);

  pcxrle_pkg::cmd_t    cmd;
  pcxrle_pkg::status_t sts;

  // Register writes are always taken
  assign cfg_i.ready = 1'b1;

  pcxrle_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (stream_i.valid),
    .in_ready_o (stream_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pcxrle_dp #(
    .DIM_BITS (DIM_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .stream_byte_i (stream_i.stream_byte),
    .cfg_valid_i   (cfg_i.valid),
    .cfg_index_i   (cfg_i.reg_index),
    .cfg_data_i    (cfg_i.wr_data),
    .out_ready_i   (pixel_o.ready),
    .out_valid_o   (pixel_o.valid),
    .pixel_value_o (pixel_o.pixel_value),
    .row_last_o    (pixel_o.row_last),
    .image_last_o  (pixel_o.image_last),
    .item_last_o   (pixel_o.item_last)
  );

endmodule

// ----- design/pcxrle_chk.sv -----
// Port checker of the PCX row decoder and its bind to the top level.
module pcxrle_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] pixel_value_i,
  input logic       row_last_i,
  input logic       image_last_i,
  input logic       item_last_i
);

  // Last pixel of the image is also last of its row
  a_image_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && image_last_i |-> row_last_i)
    else $error("image_last without row_last");

  // A row end closes the span of its byte
  a_row_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && row_last_i |-> item_last_i)
    else $error("row_last without item_last");

  // Input is held off while a run still has pixels to give
  a_run_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !item_last_i |-> !in_ready_i)
    else $error("byte taken in the middle of a run");

  // A stalled pixel holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(pixel_value_i)
      && $stable(row_last_i) && $stable(image_last_i) && $stable(item_last_i))
    else $error("stalled pixel changed");

endmodule

bind pcx_rle_row_decoder pcxrle_chk u_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_i    (stream_i.ready),
  .out_valid_i   (pixel_o.valid),
  .out_ready_i   (pixel_o.ready),
  .pixel_value_i (pixel_o.pixel_value),
  .row_last_i    (pixel_o.row_last),
  .image_last_i  (pixel_o.image_last),
  .item_last_i   (pixel_o.item_last)
);
